/* rtl/core/mfdf_pkg.sv */
// Package for the mesh flood duplicate filter: field widths, register
// indexes, result codes and the search handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfdf_pkg;
	localparam int ADDR_W    = 14;
	localparam int ID_W      = 7;
	localparam int TTL_W     = 4;
	localparam int KEY_W     = ADDR_W + ID_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_ADDR = 2'd1;

	localparam logic [ADDR_W-1:0] OWN_ADDR_RST   = 14'd1;
	localparam logic [ADDR_W-1:0] GROUP_ADDR_RST = 14'd1003;

	typedef enum logic [1:0] {
		ACT_DROP_DUP     = 2'd0,
		ACT_DELIVER      = 2'd1,
		ACT_RELAY        = 2'd2,
		ACT_DROP_EXPIRED = 2'd3
	} action_t;

	typedef enum logic {
		SR_IDLE,
		SR_SCAN
	} search_state_t;

	// Lookup request: relay selects the bounce history, otherwise the local one.
	typedef struct packed {
		logic             valid;
		logic             relay;
		logic [KEY_W-1:0] key;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} srch_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/mfdf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mfdf_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/mfdf_search.sv */
// History search engine: both key histories share one RAM, scanned one entry
// per cycle; a miss stores the key at the next slot, the oldest once full.
// Depends on mfdf_pkg and mfdf_ram.
`timescale 1ns / 1ps
`default_nettype none
module mfdf_search #(
	parameter int HISTORY_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mfdf_pkg::srch_req_t   req,
	output mfdf_pkg::srch_rsp_t        rsp
);
	import mfdf_pkg::*;

	localparam int IDX_W    = $clog2(HISTORY_DEPTH);
	localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
	localparam int RAM_ADDR = IDX_W + 1;
	localparam int RAM_DEP  = 2 ** RAM_ADDR;

	search_state_t    state_q, state_d;
	logic             relay_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	// Entries fill in pointer order, so an entry is valid when its index is
	// below the fill count.
	logic [CNT_W-1:0] fill_q [2];
	logic [IDX_W-1:0] wptr_q [2];

	logic             issue;
	logic             match;
	logic             store;
	logic [KEY_W-1:0] rd_data;
	logic [CNT_W-1:0] cur_fill;
	logic [IDX_W-1:0] cur_wptr;

	assign cur_fill = fill_q[relay_q];
	assign cur_wptr = wptr_q[relay_q];
	assign issue    = (state_q == SR_SCAN) && (rd_idx_q < cur_fill);
	assign match    = rd_vld_s1 && (rd_data == key_q);

	always_comb begin
		state_d  = state_q;
		rsp.done = 1'b0;
		rsp.hit  = 1'b0;
		store    = 1'b0;
		case (state_q)
			SR_IDLE: begin
				if (req.valid) begin
					state_d = SR_SCAN;
				end
			end
			SR_SCAN: begin
				if (match) begin
					rsp.done = 1'b1;
					rsp.hit  = 1'b1;
					state_d  = SR_IDLE;
				end else if (!issue && !rd_vld_s1) begin
					rsp.done = 1'b1;
					store    = 1'b1;
					state_d  = SR_IDLE;
				end
			end
			default: state_d = SR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SR_IDLE;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			wptr_q[0] <= '0;
			wptr_q[1] <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue && !rsp.done;
			if (state_q == SR_IDLE) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (store) begin
				if (cur_wptr == IDX_W'(HISTORY_DEPTH - 1)) begin
					wptr_q[relay_q] <= '0;
				end else begin
					wptr_q[relay_q] <= cur_wptr + IDX_W'(1);
				end
				if (cur_fill != CNT_W'(HISTORY_DEPTH)) begin
					fill_q[relay_q] <= cur_fill + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SR_IDLE && req.valid) begin
			relay_q <= req.relay;
			key_q   <= req.key;
		end
	end

	mfdf_ram #(
		.WIDTH(KEY_W),
		.DEPTH(RAM_DEP)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (store),
		.wr_addr({relay_q, cur_wptr}),
		.wr_data(key_q),
		.rd_en  (issue),
		.rd_addr({relay_q, rd_idx_q[IDX_W-1:0]}),
		.rd_data(rd_data)
	);
endmodule
`default_nettype wire

/* rtl/core/mesh_flood_duplicate_filter_core.sv */
// Top level of the mesh flood duplicate filter: configuration registers,
// destination test, result decision and the history search engine.
// Depends on mfdf_pkg, mfdf_search and mfdf_ram.
//
//   channel   signals                                    beat taken when
//   header    start, busy, source_addr, dest_addr,       start && !busy
//             packet_id, hops_left
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//   result    result_valid, action, hops_out             result_valid
//
// A header beat scans the selected history one entry per cycle through the
// key RAM read port. Busy stays high until the scan ends, and a hit ends it
// early. The result strobes on the cycle busy falls, and a new header may
// start in that same cycle. Reset empties both histories at once by clearing
// their fill counts. The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module mesh_flood_duplicate_filter_core #(
	parameter int HISTORY_DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [mfdf_pkg::ADDR_W-1:0]       source_addr,
	input  wire logic [mfdf_pkg::ADDR_W-1:0]       dest_addr,
	input  wire logic [mfdf_pkg::ID_W-1:0]         packet_id,
	input  wire logic [mfdf_pkg::TTL_W-1:0]        hops_left,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mfdf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mfdf_pkg::ADDR_W-1:0]       cfg_data,
	output logic                                   result_valid,
	output logic [1:0]                             action,
	output logic [mfdf_pkg::TTL_W-1:0]             hops_out
);
	import mfdf_pkg::*;

	logic [ADDR_W-1:0] own_addr_q;
	logic [ADDR_W-1:0] group_addr_q;
	logic              busy_q;
	logic              relay_q;
	logic [TTL_W-1:0]  ttl_q;
	logic              res_vld_q;
	action_t           act_q;
	logic [TTL_W-1:0]  hops_q;

	logic      accept;
	logic      is_local;
	srch_req_t req;
	srch_rsp_t rsp;
	action_t   act_d;
	logic [TTL_W-1:0] hops_d;

	assign cfg_ready    = 1'b1;
	assign busy         = busy_q;
	assign accept       = start && !busy_q;
	assign is_local     = (dest_addr == own_addr_q) || (dest_addr == group_addr_q);
	assign result_valid = res_vld_q;
	assign action       = act_q;
	assign hops_out     = hops_q;

	assign req.valid = accept;
	assign req.relay = !is_local;
	assign req.key   = {source_addr, packet_id};

	always_comb begin
		hops_d = '0;
		if (rsp.hit) begin
			act_d = ACT_DROP_DUP;
		end else if (!relay_q) begin
			act_d = ACT_DELIVER;
		end else if (ttl_q != '0) begin
			act_d  = ACT_RELAY;
			hops_d = ttl_q - TTL_W'(1);
		end else begin
			act_d = ACT_DROP_EXPIRED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= OWN_ADDR_RST;
			group_addr_q <= GROUP_ADDR_RST;
			busy_q       <= 1'b0;
			res_vld_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_OWN_ADDR) begin
				own_addr_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_GROUP_ADDR) begin
				group_addr_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (rsp.done) begin
				busy_q <= 1'b0;
			end
			res_vld_q <= rsp.done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			relay_q <= !is_local;
			ttl_q   <= hops_left;
		end
		if (rsp.done) begin
			act_q  <= act_d;
			hops_q <= hops_d;
		end
	end

	mfdf_search #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);
endmodule
`default_nettype wire
